>>> hw/rtl/itfr_pkg.sv
// itfr_pkg: constants, types and opcodes of the interpolation table
// no dependencies
`default_nettype none
package itfr_pkg;
   localparam int TABLE_DEPTH = 512;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = 10;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FWD   = 2'd1,
      OP_REV   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   localparam logic [0:0] CSR_ENTRIES = 1'b0;
   localparam logic [0:0] CSR_STEP    = 1'b1;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

>>> hw/rtl/itfr_ram.sv
// itfr_ram: generic single port write, single port read ram, registered read
// no dependencies
`default_nettype none
module itfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/itfr_div.sv
// itfr_div: unsigned 64 by 32 restoring divider, one quotient bit per cycle
// depends on itfr_pkg
`default_nettype none
module itfr_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire itfr_pkg::div_req_type req,
   output logic                     done,
   output logic [31:0]              quotient
);
   import itfr_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, num_ff[63]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.dividend;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits 32 bits
         if (!diff[32]) begin
            rem_in = diff[31:0];
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (req.start) begin
         den_ff <= req.divisor;
      end
   end

   // quotient fits 32 bits since q-a0 <= a1-a0
   assign done     = done_ff;
   assign quotient = num_ff[31:0];
endmodule
`default_nettype wire

>>> hw/rtl/interp_table_forward_reverse.sv
// interp_table_forward_reverse: breakpoint table with forward/reverse lookup
// depends on itfr_pkg, itfr_ram, itfr_div
//
// channel  | ports                         | handshake
// request  | req_opcode .. req_query       | start & !busy
// response | rsp_result_value, rsp_status  | rsp_valid, one cycle
// csr      | csr_wr_en, csr_index, csr_data| csr_wr_en
//
// a write, an unused opcode or a lookup on an empty table goes from idle
// straight to S_DONE, which strobes rsp_valid; a lookup clamped at an end
// reads only the first and last entries; any other lookup also scans all n
// entries, one per cycle via the ram read port, and in linear mode the divider.
// reset clears control and csr registers; table contents are undefined.
// the receiver cannot stall; busy is high from start until rsp_valid.
`default_nettype none
module interp_table_forward_reverse (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [8:0]                   req_entry_index,
   input  wire logic signed [31:0]           req_entry_key,
   input  wire logic signed [31:0]           req_entry_value,
   input  wire logic signed [31:0]           req_query,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_result_value,
   output logic [1:0]                        rsp_status,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_index,
   input  wire logic [9:0]                   csr_data
);
   import itfr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_FIRST, S_RD_LAST, S_ENDS, S_SCAN, S_DIV_GO, S_DIV_WAIT, S_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   entries_ff;
   logic               step_ff;
   logic [CNT_W-1:0]   n_eff;
   logic               rev_ff;
   logic signed [31:0] q_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   logic [CNT_W-1:0]   scan_ff;     // index of entry arriving from the ram
   logic signed [31:0] pa_ff, pb_ff; // previous entry
   logic signed [31:0] fa_ff, fb_ff; // first entry
   logic               hit_ff;
   logic               need_div_ff;
   logic signed [31:0] r_ff;
   logic signed [31:0] sb0_ff;
   logic               sneg_ff;
   logic [31:0]        sden_ff;
   logic [31:0]        smag_ff, snum_ff;
   logic signed [31:0] res_ff;
   logic [1:0]         st_ff;
   logic               valid_ff;

   logic [31:0] k_rd, v_rd;
   logic        ram_we;
   logic signed [31:0] ca, cb;
   logic        div_done;
   logic [31:0] div_q;
   div_req_type div_req;

   assign n_eff = (entries_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_ff;
   assign ram_we = start && !busy && (req_opcode == OP_WRITE)
                   && ({1'b0, req_entry_index} < 10'(TABLE_DEPTH));

   itfr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_entry_index[IDX_W-1:0]),
      .wr_data(req_entry_key), .rd_addr(rd_addr_ff), .rd_data(k_rd));
   itfr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_entry_index[IDX_W-1:0]),
      .wr_data(req_entry_value), .rd_addr(rd_addr_ff), .rd_data(v_rd));

   assign ca = rev_ff ? $signed(v_rd) : $signed(k_rd);
   assign cb = rev_ff ? $signed(k_rd) : $signed(v_rd);

   function automatic logic signed [31:0] mean2(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
      logic signed [32:0] s;
      begin
         s = 33'(p) + 33'(q);
         if (s[32]) s = s + 33'sd1;
         return s[32:1];
      end
   endfunction

   // segment evaluation on current (ca,cb) with previous (pa,pb)
   logic               seg_hit;
   logic signed [32:0] dy, dnum, dden;
   assign seg_hit = !(q_ff < pa_ff) && !(q_ff > ca);
   assign dy   = 33'(cb) - 33'(pb_ff);
   assign dnum = 33'(q_ff) - 33'(pa_ff);
   assign dden = 33'(ca) - 33'(pa_ff);

   assign div_req = '{start:    (state_ff == S_DIV_GO) && hit_ff && need_div_ff,
                      dividend: 64'(smag_ff) * 64'(snum_ff),
                      divisor:  sden_ff};

   itfr_div u_div (.clock(clock), .reset(reset), .req(div_req),
                   .done(div_done), .quotient(div_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         entries_ff <= '0;
         step_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ENTRIES: entries_ff <= csr_data;
               CSR_STEP:    step_ff    <= csr_data[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  q_ff   <= req_query;
                  rev_ff <= (req_opcode == OP_REV);
                  res_ff <= '0;
                  st_ff  <= ST_OK;
                  hit_ff <= 1'b0;
                  need_div_ff <= 1'b0;
                  rd_addr_ff <= '0;
                  case (req_opcode) inside
                     OP_FWD, OP_REV: begin
                        if (n_eff == '0) begin
                           st_ff    <= ST_EMPTY;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_RD_FIRST;
                        end
                     end
                     OP_WRITE: begin
                        if ({1'b0, req_entry_index} >= 10'(TABLE_DEPTH)) st_ff <= ST_RANGE;
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_RD_FIRST: begin
               // address 0 in flight
               rd_addr_ff <= IDX_W'(n_eff - CNT_W'(1));
               state_ff   <= S_RD_LAST;
            end
            S_RD_LAST: begin
               fa_ff <= ca;
               fb_ff <= cb;
               rd_addr_ff <= '0;
               state_ff   <= S_ENDS;
            end
            S_ENDS: begin
               // ca/cb is the last entry
               if (q_ff <= fa_ff) begin
                  res_ff <= fb_ff; state_ff <= S_DONE;
               end else if (q_ff >= ca) begin
                  res_ff <= cb; state_ff <= S_DONE;
               end else begin
                  // restart stream from entry 0
                  rd_addr_ff <= IDX_W'(1);
                  scan_ff    <= '0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_addr_ff <= rd_addr_ff + IDX_W'(1);
               scan_ff    <= scan_ff + CNT_W'(1);
               pa_ff <= ca;
               pb_ff <= cb;
               if (scan_ff != '0 && seg_hit) begin
                  hit_ff <= 1'b1;
                  if (dden == '0) begin
                     r_ff <= mean2(pb_ff, cb); need_div_ff <= 1'b0;
                  end else if (step_ff) begin
                     r_ff <= rev_ff ? mean2(pb_ff, cb) : pb_ff;
                     need_div_ff <= 1'b0;
                  end else begin
                     need_div_ff <= 1'b1;
                     sb0_ff  <= pb_ff;
                     sneg_ff <= dy[32];
                     smag_ff <= dy[32] ? 32'(-dy) : dy[31:0];
                     snum_ff <= dnum[31:0];
                     sden_ff <= dden[31:0];
                  end
               end
               if (scan_ff == n_eff - CNT_W'(1)) begin
                  state_ff  <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               // previous cycle resolved hit state; product feeds the divider here
               if (!hit_ff) begin
                  st_ff <= ST_NOMATCH; state_ff <= S_DONE;
               end else if (!need_div_ff) begin
                  res_ff <= r_ff; state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  res_ff <= sneg_ff ? 32'(33'(sb0_ff) - {1'b0, div_q})
                                    : 32'(33'(sb0_ff) + {1'b0, div_q});
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;
endmodule
`default_nettype wire

>>> hw/rtl/itfr_checker.sv
// itfr_checker: port-level assertions on the interpolation table
// depends on itfr_pkg; bound to interp_table_forward_reverse
`default_nettype none
module itfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_result_value,
   input wire logic [1:0]  rsp_status
);
   import itfr_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without item");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_result_value == '0)
      else $error("nonzero result with error status");
endmodule

bind interp_table_forward_reverse itfr_checker u_itfr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_result_value(rsp_result_value),
   .rsp_status(rsp_status));
`default_nettype wire
